// File: design/sha_pkg.sv
//------------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
//------------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned NumWords = 8;
    localparam int unsigned QDepth   = 4;

    // One schedule word passed from the front to the back.
    typedef struct packed {
        logic               final_blk;  // set on word 15 of the closing block
        logic [WordW-1:0]   word;
    } t_qent;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// File: design/sha256_stream_hasher_core.sv
//------------------------------------------------------------------------------
// sha256_stream_hasher_core
// Streaming SHA-256: one message byte per input word, digest out as 8 words.
//------------------------------------------------------------------------------
// Block flow: the back loads 16 words, runs 64 rounds and folds once per block; the
// four-word queue takes only 16 bytes while it is busy, so the other 48 bytes come
// in during the load.
// Digest: the first word is ready once the last padding block is compressed, one or
// two per message, then eight words back to back while the output is ready.
// Reset: synchronous active-low; the hash state returns to the initial values.
//------------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,   // [7:0] msg_byte
    input  wire logic           s_axis_tuser,   // has_byte
    input  wire logic           s_axis_tlast,   // end_of_message
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                m_axis_tlast    // last_word
);
    import sha_pkg::*;

    // The front packs bytes and pads; the queue lets it keep taking bytes of
    // the next block while the back is busy compressing the current one.
    logic       w_q_push, w_q_pop, w_q_full, w_q_empty;
    t_qent      w_q_in, w_q_out;
    logic [31:0] w_word;
    logic [2:0]  w_idx;

    sha_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_msg_byte (s_axis_tdata),
        .i_has_byte (s_axis_tuser),
        .i_end      (s_axis_tlast),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    sha_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    sha_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (w_q_out),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_digest_word (w_word),
        .o_word_index  (w_idx),
        .o_last_word   (m_axis_tlast)
    );

    // Digest word in the low bits, its index above, zero fill to 40 bits.
    assign m_axis_tdata = {5'b00000, w_idx, w_word};

endmodule

`default_nettype wire

// File: design/sha_fifo.sv
//------------------------------------------------------------------------------
// sha_fifo
// Short first-in first-out queue of schedule words between front and back.
//------------------------------------------------------------------------------
`default_nettype none

module sha_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sha_pkg::t_qent i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output sha_pkg::t_qent      o_data,
    output logic                o_empty
);
    import sha_pkg::*;

    localparam int unsigned PtrW = $clog2(QDepth);

    t_qent              r_mem [QDepth];
    logic [PtrW-1:0]    r_wp, r_rp;
    logic [PtrW:0]      r_cnt;

    assign o_full  = (r_cnt == (PtrW+1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/sha_front.sv
//------------------------------------------------------------------------------
// sha_front
// Takes message bytes, packs them into big-endian words, counts the length
// and generates the padding words at the end of a message.
//------------------------------------------------------------------------------
`default_nettype none

module sha_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_msg_byte,
    input  wire logic           i_has_byte,
    input  wire logic           i_end,
    input  wire logic           i_q_full,
    output logic                o_q_push,
    output sha_pkg::t_qent      o_q_data
);
    import sha_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PAD  = 1'b1;
    localparam logic [5:0] LenLastPos = 6'd55;

    logic           r_st, n_st;
    logic [5:0]     r_cnt, n_cnt;
    logic [63:0]    r_len, n_len;
    logic [31:0]    r_part, n_part;
    logic           r_first, n_first;
    logic           r_len_ok, n_len_ok;

    logic           w_acc;
    logic [31:0]    w_byte_word;
    logic [31:0]    w_pad_word;
    logic [5:0]     w_cnt_inc;
    logic [3:0]     w_wi;

    // Place a byte into the partial word at its big-endian lane.
    function automatic logic [31:0] put_byte(input logic [31:0] part,
                                             input logic [7:0] b,
                                             input logic [1:0] lane);
        logic [31:0] r;
        r = part;
        case (lane)
            2'd0:    r[31:24] = b;
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8]  = b;
            default: r[7:0]   = b;
        endcase
        return r;
    endfunction

    assign o_ready     = (r_st == ST_IDLE) && !i_q_full;
    assign w_acc       = i_valid && o_ready;
    assign w_byte_word = put_byte(r_part, i_msg_byte, r_cnt[1:0]);
    assign w_pad_word  = put_byte(r_part, 8'h80, r_cnt[1:0]);
    assign w_cnt_inc   = r_cnt + 6'd1;
    assign w_wi        = r_cnt[5:2];

    always_comb begin
        n_st     = r_st;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_part   = r_part;
        n_first  = r_first;
        n_len_ok = r_len_ok;
        o_q_push = 1'b0;
        o_q_data = '0;
        case (r_st)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_has_byte) begin
                        n_len  = r_len + 64'd8;
                        n_cnt  = w_cnt_inc;
                        n_part = w_byte_word;
                        if (r_cnt[1:0] == 2'd3) begin
                            o_q_push = 1'b1;
                            o_q_data.word = w_byte_word;
                            n_part = '0;
                        end
                    end
                    if (i_end) begin
                        n_st     = ST_PAD;
                        n_first  = 1'b1;
                        n_len_ok = (i_has_byte ? w_cnt_inc : r_cnt) <= LenLastPos;
                    end
                end
            end
            ST_PAD: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_first  = 1'b0;
                    n_part   = '0;
                    n_cnt    = {w_wi + 4'd1, 2'b00};
                    if (r_first) begin
                        o_q_data.word = w_pad_word;
                    end else if (r_len_ok && w_wi == 4'd14) begin
                        o_q_data.word = r_len[63:32];
                    end else if (r_len_ok && w_wi == 4'd15) begin
                        o_q_data.word = r_len[31:0];
                    end
                    if (w_wi == 4'd15) begin
                        if (r_len_ok) begin
                            o_q_data.final_blk = 1'b1;
                            n_st  = ST_IDLE;
                            n_len = '0;
                        end
                        n_len_ok = 1'b1;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_cnt    <= '0;
            r_len    <= '0;
            r_part   <= '0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_part   <= n_part;
            r_first  <= n_first;
            r_len_ok <= n_len_ok;
        end
    end

endmodule

`default_nettype wire

// File: design/sha_back.sv
//------------------------------------------------------------------------------
// sha_back
// Loads 16 schedule words, runs 64 compression rounds one per cycle, folds
// the result into the hash state and emits the digest after a closing block.
//------------------------------------------------------------------------------
`default_nettype none

module sha_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sha_pkg::t_qent i_q_data,
    input  wire logic           i_q_empty,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);
    import sha_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]     r_st;
    logic [5:0]     r_ctr;
    logic [2:0]     r_idx;
    logic           r_final;
    logic [31:0]    r_w [16];
    logic [31:0]    r_v [NumWords];
    logic [31:0]    r_h [NumWords];

    logic [31:0]    w_new_w, w_t1, w_t2, w_ch, w_maj;

    assign w_new_w = sml_s1(r_w[14]) + r_w[9] + sml_s0(r_w[1]) + r_w[0];
    assign w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1    = r_v[7] + big_s1(r_v[4]) + w_ch + round_k(r_ctr) + r_w[0];
    assign w_t2    = big_s0(r_v[0]) + w_maj;

    assign o_q_pop       = (r_st == ST_LOAD) && !i_q_empty;
    assign o_valid       = (r_st == ST_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    // Schedule window and working variables carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_q_data.word;
        end else if (r_st == ST_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new_w;
        end
        if (o_q_pop && r_ctr == 6'd15) begin
            for (int i = 0; i < NumWords; i++) r_v[i] <= r_h[i];
        end else if (r_st == ST_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_LOAD;
            r_ctr   <= '0;
            r_idx   <= '0;
            r_final <= 1'b0;
            for (int i = 0; i < NumWords; i++) r_h[i] <= init_h(3'(i));
        end else begin
            case (r_st)
                ST_LOAD: begin
                    if (o_q_pop) begin
                        r_ctr <= r_ctr + 6'd1;
                        if (r_ctr == 6'd15) begin
                            r_final <= i_q_data.final_blk;
                            r_ctr   <= '0;
                            r_st    <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    r_ctr <= r_ctr + 6'd1;
                    if (r_ctr == 6'd63) r_st <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < NumWords; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_idx <= '0;
                    r_st  <= r_final ? ST_OUT : ST_LOAD;
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < NumWords; i++) r_h[i] <= init_h(3'(i));
                            r_st <= ST_LOAD;
                        end
                    end
                end
                default: r_st <= ST_LOAD;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/sha_chk.sv
//------------------------------------------------------------------------------
// sha_chk
// Port-level checks of the digest output of the SHA-256 stream hasher.
//------------------------------------------------------------------------------
`default_nettype none

module sha_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // Digest words of one message leave back to back.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("digest burst broken");

    // The closing word carries index seven.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == 3'd7)
        else $error("last word has wrong index");

    // Each accepted non-final word is followed by the next index.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
        else $error("word index did not advance");

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");

endmodule

bind sha256_stream_hasher_core sha_chk u_sha_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
